### hdl/binary_max_heap_queue_assert.svh
// Assertion macros for the binary max-heap queue.
// Used by the top level only; depends on nothing else.
`ifndef BINARY_MAX_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define BMHQ_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition one edge implies another at the following edge.
`define BMHQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

// Checks that a condition implies another at the same edge.
`define BMHQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) ante |-> cons) else $error(msg);

`endif

### hdl/bmhq_pkg.sv
// Shared types and constants of the binary max-heap queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package bmhq_pkg;

   // Sizing of the heap store.
   localparam int CAPACITY    = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int ADDR_WIDTH  = $clog2(CAPACITY);
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
   localparam int CHILD_WIDTH = ADDR_WIDTH + 2;

   // Fixed widths of the word fields.
   localparam int VALUE_WIDTH     = 32;
   localparam int ENTRY_CNT_WIDTH = 7;
   localparam int STATUS_WIDTH    = 2;

   // Request kinds.
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                   req_type;
      logic [VALUE_WIDTH-1:0] push_value;
   } bmhq_req_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0]     top_value;
      logic                       not_empty;
      logic [ENTRY_CNT_WIDTH-1:0] entry_count;
      logic [STATUS_WIDTH-1:0]    status;
   } bmhq_rsp_type;

   // Datapath operations issued by the controller, one per cycle.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_FULL,
      OP_EMPTY,
      OP_GROW,
      OP_SHRINK,
      OP_READ_LAST,
      OP_LOAD_LAST,
      OP_WRITE_VAL,
      OP_READ_PARENT,
      OP_MOVE_PARENT,
      OP_READ_LEFT,
      OP_READ_RIGHT,
      OP_MOVE_LEFT,
      OP_MOVE_RIGHT
   } bmhq_op_type;

   typedef struct packed {
      bmhq_op_type op;
      logic        rsp_load;
   } bmhq_cmd_type;

   typedef struct packed {
      logic is_pop;
      logic is_full;
      logic is_empty;
      logic last_one;
      logic at_root;
      logic left_in;
      logic up_move;
      logic dn_left;
      logic dn_right;
   } bmhq_status_type;

endpackage

### hdl/bmhq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/bmhq_datapath.sv
// Datapath of the binary max-heap queue: heap RAM, sift registers and result register.
// Depends on bmhq_pkg and bmhq_ram.
module bmhq_datapath
   import bmhq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  bmhq_req_type    req_data,
   input  bmhq_cmd_type    cmd,
   output bmhq_status_type status,
   output bmhq_rsp_type    rsp_data
);

   logic                     op_ff;
   logic [DATA_WIDTH-1:0]    val_ff,   val_in;
   logic [DATA_WIDTH-1:0]    child_ff, child_in;
   logic [DATA_WIDTH-1:0]    top_ff,   top_in;
   logic [ADDR_WIDTH-1:0]    pos_ff,   pos_in;
   logic [COUNT_WIDTH-1:0]   cnt_ff,   cnt_in;
   logic [STATUS_WIDTH-1:0]  stat_ff,  stat_in;
   bmhq_rsp_type             rsp_ff,   rsp_in;

   logic [ADDR_WIDTH-1:0]    parent_addr;
   logic [CHILD_WIDTH-1:0]   left_idx;
   logic [CHILD_WIDTH-1:0]   right_idx;
   logic [CHILD_WIDTH-1:0]   cnt_wide;
   logic [DATA_WIDTH-1:0]    best_val;
   logic                     left_better;
   logic                     right_in;

   logic                     wr_en;
   logic [ADDR_WIDTH-1:0]    wr_addr;
   logic [DATA_WIDTH-1:0]    wr_data;
   logic                     rd_en;
   logic [ADDR_WIDTH-1:0]    rd_addr;
   logic [DATA_WIDTH-1:0]    rd_data;

   // Tree neighbors of the current hole position.
   assign parent_addr = (pos_ff - ADDR_WIDTH'(1)) >> 1;
   assign left_idx    = {1'b0, pos_ff, 1'b1};
   assign right_idx   = left_idx + CHILD_WIDTH'(1);
   assign cnt_wide    = CHILD_WIDTH'(cnt_ff);
   assign right_in    = right_idx < cnt_wide;

   // Sift-down choice: the larger child wins only when strictly larger; left wins ties.
   assign left_better = child_ff > val_ff;
   assign best_val    = left_better ? child_ff : val_ff;

   always_comb begin
      status.is_pop   = op_ff;
      status.is_full  = cnt_ff == COUNT_WIDTH'(CAPACITY);
      status.is_empty = cnt_ff == '0;
      status.last_one = cnt_ff == COUNT_WIDTH'(1);
      status.at_root  = pos_ff == '0;
      status.left_in  = left_idx < cnt_wide;
      status.up_move  = rd_data < val_ff;
      status.dn_right = right_in && (rd_data > best_val);
      status.dn_left  = left_better && !status.dn_right;
   end

   // Memory port control and register updates for each operation.
   always_comb begin
      val_in   = val_ff;
      child_in = child_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      stat_in  = stat_ff;
      wr_en    = 1'b0;
      wr_addr  = pos_ff;
      wr_data  = val_ff;
      rd_en    = 1'b0;
      rd_addr  = parent_addr;
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            val_in  = DATA_WIDTH'(req_data.push_value);
            stat_in = STATUS_OK;
         end
         OP_FULL: begin
            stat_in = STATUS_FULL;
         end
         OP_EMPTY: begin
            stat_in = STATUS_EMPTY;
         end
         OP_GROW: begin
            pos_in = ADDR_WIDTH'(cnt_ff);
            cnt_in = cnt_ff + COUNT_WIDTH'(1);
         end
         OP_SHRINK: begin
            cnt_in = cnt_ff - COUNT_WIDTH'(1);
         end
         OP_READ_LAST: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_WIDTH'(cnt_ff - COUNT_WIDTH'(1));
            cnt_in  = cnt_ff - COUNT_WIDTH'(1);
         end
         OP_LOAD_LAST: begin
            val_in = rd_data;
            pos_in = '0;
         end
         OP_WRITE_VAL: begin
            wr_en = 1'b1;
         end
         OP_READ_PARENT: begin
            rd_en = 1'b1;
         end
         OP_MOVE_PARENT: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            pos_in  = parent_addr;
         end
         OP_READ_LEFT: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_WIDTH'(left_idx);
         end
         OP_READ_RIGHT: begin
            child_in = rd_data;
            rd_en    = 1'b1;
            rd_addr  = ADDR_WIDTH'(right_idx);
         end
         OP_MOVE_LEFT: begin
            wr_en   = 1'b1;
            wr_data = child_ff;
            pos_in  = ADDR_WIDTH'(left_idx);
         end
         OP_MOVE_RIGHT: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            pos_in  = ADDR_WIDTH'(right_idx);
         end
         default: begin
         end
      endcase
   end

   // The root copy follows every write to the root slot.
   assign top_in = (wr_en && (wr_addr == '0)) ? wr_data : top_ff;

   // Result word, built from the state after the request.
   always_comb begin
      rsp_in             = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.top_value   = (cnt_ff != '0) ? VALUE_WIDTH'(top_ff) : '0;
         rsp_in.not_empty   = cnt_ff != '0;
         rsp_in.entry_count = ENTRY_CNT_WIDTH'(cnt_ff);
         rsp_in.status      = stat_ff;
      end
   end

   // Fill count is control state; the rest is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         op_ff <= req_data.req_type;
      end
      val_ff   <= val_in;
      child_ff <= child_in;
      top_ff   <= top_in;
      pos_ff   <= pos_in;
      stat_ff  <= stat_in;
      rsp_ff   <= rsp_in;
   end

   bmhq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_data = rsp_ff;

endmodule

### hdl/bmhq_controller.sv
// Controller of the binary max-heap queue: sequences push and pop sifts.
// Depends on bmhq_pkg.
module bmhq_controller
   import bmhq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            rsp_stall,
   input  bmhq_status_type status,
   output logic            req_stall,
   output logic            rsp_valid,
   output bmhq_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_UP,
      S_UP_CMP,
      S_POP_LOAD,
      S_DN,
      S_DN_L,
      S_DN_R,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and the datapath operation for this cycle.
   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.rsp_load = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_START;
            end
         end
         S_START: begin
            if (status.is_pop) begin
               if (status.is_empty) begin
                  cmd.op   = OP_EMPTY;
                  state_in = S_DONE;
               end else if (status.last_one) begin
                  cmd.op   = OP_SHRINK;
                  state_in = S_DONE;
               end else begin
                  cmd.op   = OP_READ_LAST;
                  state_in = S_POP_LOAD;
               end
            end else begin
               if (status.is_full) begin
                  cmd.op   = OP_FULL;
                  state_in = S_DONE;
               end else begin
                  cmd.op   = OP_GROW;
                  state_in = S_UP;
               end
            end
         end
         S_UP: begin
            if (status.at_root) begin
               cmd.op   = OP_WRITE_VAL;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_READ_PARENT;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (status.up_move) begin
               cmd.op   = OP_MOVE_PARENT;
               state_in = S_UP;
            end else begin
               cmd.op   = OP_WRITE_VAL;
               state_in = S_DONE;
            end
         end
         S_POP_LOAD: begin
            cmd.op   = OP_LOAD_LAST;
            state_in = S_DN;
         end
         S_DN: begin
            if (status.left_in) begin
               cmd.op   = OP_READ_LEFT;
               state_in = S_DN_L;
            end else begin
               cmd.op   = OP_WRITE_VAL;
               state_in = S_DONE;
            end
         end
         S_DN_L: begin
            cmd.op   = OP_READ_RIGHT;
            state_in = S_DN_R;
         end
         S_DN_R: begin
            priority if (status.dn_left) begin
               cmd.op   = OP_MOVE_LEFT;
               state_in = S_DN;
            end else if (status.dn_right) begin
               cmd.op   = OP_MOVE_RIGHT;
               state_in = S_DN;
            end else begin
               cmd.op   = OP_WRITE_VAL;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // The result word leaves once the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/binary_max_heap_queue.sv
// Binary max-heap priority queue holding up to 64 unsigned 32-bit values. Each request word
// pushes a value or pops the maximum, and yields one result word with the new top, a
// non-empty flag, the entry count and a status (push on full and pop on empty leave the
// queue unchanged and are flagged). Requests are handled one at a time. A pushed value
// rises at most 6 levels toward the root, and the entry that a pop moves to the root sinks
// at most 5 levels toward a leaf. The heap RAM has a single read port, which is read once
// per level on the way up and twice per level on the way down. A stalled output register
// that still holds the previous result delays the load until the stall ends, and the next
// request is taken at the earliest in the cycle after the load. A finished result waits in
// the output register while the next request is taken. Reset is synchronous and needs no
// clearing pass.
// Depends on bmhq_pkg, bmhq_controller, bmhq_datapath and the assertion macro header.
`include "binary_max_heap_queue_assert.svh"

module binary_max_heap_queue
   import bmhq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  bmhq_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output bmhq_rsp_type rsp_data
);

   bmhq_cmd_type    cmd;
   bmhq_status_type status;
   logic            req_accept;
   logic            rsp_empty_ok;
   logic            rsp_status_ok;

   bmhq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   bmhq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // Terms checked by the assertions below.
   assign req_accept    = req_valid && !req_stall;
   assign rsp_empty_ok  = (rsp_data.not_empty == (rsp_data.entry_count != '0)) &&
                          (rsp_data.not_empty || (rsp_data.top_value == '0));
   assign rsp_status_ok = (rsp_data.status == STATUS_OK) ||
                          ((rsp_data.status == STATUS_FULL) &&
                           (rsp_data.entry_count == ENTRY_CNT_WIDTH'(CAPACITY))) ||
                          ((rsp_data.status == STATUS_EMPTY) && (rsp_data.entry_count == '0));

   // An accepted request keeps the block busy for at least the next cycle.
   `BMHQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, req_stall, "busy expected")

   // The empty flag and the top value agree with the count.
   `BMHQ_ASSERT_SAME(a_empty_consistent, clock, reset, rsp_valid, rsp_empty_ok, "empty flag")

   // A dropped push only happens at full capacity and a refused pop only when empty.
   `BMHQ_ASSERT_SAME(a_status_consistent, clock, reset, rsp_valid, rsp_status_ok, "status code")

endmodule
